### rtl/radar_frame_motion_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// radar frame motion parser assertion macros
// Shared concurrent check forms for the frame parser, clocked on i_clk and
// masked while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RADAR_FRAME_MOTION_PARSER_UNIT_MACROS_SVH
`define RADAR_FRAME_MOTION_PARSER_UNIT_MACROS_SVH

// same-cycle implication check
`define RFMP_CHECK(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (conseq)) else $error(msg);

// next-cycle implication check
`define RFMP_CHECK_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (conseq)) else $error(msg);

`endif

### rtl/rfmp_pkg.sv
// ----------------------------------------------------------------------------
// rfmp_pkg
// Constants, types and sync sequences shared by the frame parser modules.
// ----------------------------------------------------------------------------
package rfmp_pkg;

    // largest accepted payload length in bytes
    localparam int MAX_PAYLOAD = 64;
    localparam int PCNT_W      = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] HDR_B0  = 8'hF4;
    localparam logic [7:0] HDR_B1  = 8'hF3;
    localparam logic [7:0] HDR_B2  = 8'hF2;
    localparam logic [7:0] HDR_B3  = 8'hF1;
    localparam logic [7:0] TAIL_B0 = 8'hF8;
    localparam logic [7:0] TAIL_B1 = 8'hF7;
    localparam logic [7:0] TAIL_B2 = 8'hF6;
    localparam logic [7:0] TAIL_B3 = 8'hF5;

    // target state code that defers to the second payload byte
    localparam logic [7:0] TGT_DEFER = 8'h02;
    localparam logic [7:0] TGT_MAX   = 8'h03;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_TAIL   = 2'd2,
        ERR_TARGET = 2'd3
    } t_err_code;

    // control state of the parser
    typedef struct packed {
        logic [2:0]        hdr_matched;
        logic [1:0]        len_seen;
        logic [15:0]       frame_length;
        logic [PCNT_W-1:0] payload_count;
        logic              checksum_pending;
        logic [1:0]        tail_matched;
        logic              motion_state;
        logic [15:0]       errors_seen;
    } t_parse_state;

    // per-byte result and payload head write strobes
    typedef struct packed {
        logic      frame_done;
        t_err_code err;
        logic      trigger;
        logic      wr_head0;
        logic      wr_head1;
    } t_step_res;

    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = HDR_B0;
            2'd1:    b = HDR_B1;
            2'd2:    b = HDR_B2;
            default: b = HDR_B3;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = TAIL_B0;
            2'd1:    b = TAIL_B1;
            2'd2:    b = TAIL_B2;
            default: b = TAIL_B3;
        endcase
        return b;
    endfunction

endpackage

### rtl/rfmp_step.sv
// ----------------------------------------------------------------------------
// rfmp_step
// Next-state and result logic of the frame parser for one received byte.
// ----------------------------------------------------------------------------
module rfmp_step (
    input  logic                  [7:0] i_rx_byte,
    input  rfmp_pkg::t_parse_state      i_state,
    input  logic                  [7:0] i_head0,
    input  logic                  [7:0] i_head1,
    output rfmp_pkg::t_parse_state      o_state,
    output rfmp_pkg::t_step_res         o_res
);
    import rfmp_pkg::*;

    logic [15:0] len_full;
    logic        len_bad;
    logic        do_clear;
    logic        do_count;
    logic        second_ok;
    logic        tgt_known;
    logic [7:0]  tgt;
    logic        tgt_active;

    // full length once the high byte arrives
    assign len_full = {i_rx_byte, i_state.frame_length[7:0]};
    assign len_bad  = (len_full == 16'd0) || (len_full > 16'(MAX_PAYLOAD));

    // target state decode from the payload head
    always_comb begin
        second_ok = (i_state.frame_length > 16'd1) && (i_head1 <= TGT_MAX);
        tgt       = i_head0;
        tgt_known = 1'b1;
        if (((i_head0 == TGT_DEFER) || (i_head0 > TGT_MAX)) && second_ok) begin
            tgt = i_head1;
        end else if (i_head0 > TGT_MAX) begin
            tgt_known = 1'b0;
        end
        tgt_active = (tgt != 8'd0);
    end

    // parser step
    always_comb begin
        o_state  = i_state;
        o_res    = '0;
        do_clear = 1'b0;
        do_count = 1'b0;
        if (i_state.hdr_matched < 3'd4) begin
            if (i_rx_byte == hdr_byte(i_state.hdr_matched[1:0])) begin
                o_state.hdr_matched = i_state.hdr_matched + 3'd1;
            end else if (i_rx_byte == HDR_B0) begin
                o_state.hdr_matched = 3'd1;
            end else begin
                o_state.hdr_matched = 3'd0;
            end
        end else if (i_state.len_seen < 2'd2) begin
            if (i_state.len_seen == 2'd0) begin
                o_state.frame_length = {8'h00, i_rx_byte};
                o_state.len_seen     = 2'd1;
            end else if (len_bad) begin
                o_res.err = ERR_LENGTH;
                do_count  = 1'b1;
                do_clear  = 1'b1;
            end else begin
                o_state.frame_length     = len_full;
                o_state.len_seen         = 2'd2;
                o_state.payload_count    = '0;
                o_state.tail_matched     = 2'd0;
                o_state.checksum_pending = 1'b1;
            end
        end else if (16'(i_state.payload_count) < i_state.frame_length) begin
            o_res.wr_head0        = (i_state.payload_count == PCNT_W'(0));
            o_res.wr_head1        = (i_state.payload_count == PCNT_W'(1));
            o_state.payload_count = i_state.payload_count + PCNT_W'(1);
        end else if (i_state.checksum_pending) begin
            o_state.checksum_pending = 1'b0;
            if (i_rx_byte == TAIL_B0) begin
                o_state.tail_matched = 2'd1;
            end
        end else if (i_rx_byte == tail_byte(i_state.tail_matched)) begin
            if (i_state.tail_matched == 2'd3) begin
                o_res.frame_done = 1'b1;
                do_clear         = 1'b1;
                if (tgt_known) begin
                    o_res.trigger        = !i_state.motion_state && tgt_active;
                    o_state.motion_state = tgt_active;
                end else begin
                    o_res.err = ERR_TARGET;
                    do_count  = 1'b1;
                end
            end else begin
                o_state.tail_matched = i_state.tail_matched + 2'd1;
            end
        end else begin
            o_res.err = ERR_TAIL;
            do_count  = 1'b1;
            do_clear  = 1'b1;
        end

        // back to header hunt
        if (do_clear) begin
            o_state.hdr_matched      = 3'd0;
            o_state.len_seen         = 2'd0;
            o_state.frame_length     = 16'd0;
            o_state.payload_count    = '0;
            o_state.checksum_pending = 1'b0;
            o_state.tail_matched     = 2'd0;
        end

        // saturating error count
        if (do_count && (i_state.errors_seen != 16'hFFFF)) begin
            o_state.errors_seen = i_state.errors_seen + 16'd1;
        end
    end

endmodule

### rtl/radar_frame_motion_parser_unit.sv
// ----------------------------------------------------------------------------
// radar_frame_motion_parser_unit
// Deframes sensor frames one byte per request and reports motion and errors.
// The result of a byte is registered and shown in the cycle after it is accepted.
// Throughput: one byte per cycle unless a held, undrained result stalls o_rx_ready;
// the single parse step sits between the parser state registers and the result register.
// Reset: synchronous, active low; clears parser state, motion and error count.
// ----------------------------------------------------------------------------
`include "radar_frame_motion_parser_unit_macros.svh"

module radar_frame_motion_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_frame_done,
    output logic [1:0] o_error_code,
    output logic       o_motion_active,
    output logic       o_motion_trigger,
    output logic [15:0] o_error_count
);
    import rfmp_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    t_step_res    n_res;
    logic [7:0]   r_head0;
    logic [7:0]   r_head1;
    logic         r_res_valid;
    logic         r_frame_done;
    t_err_code    r_error_code;
    logic         r_motion_trigger;
    logic         rx_take;

    // accept a byte whenever the result slot is free or being drained
    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign rx_take    = i_rx_valid && o_rx_ready;

    rfmp_step u_step (
        .i_rx_byte (i_rx_byte),
        .i_state   (r_state),
        .i_head0   (r_head0),
        .i_head1   (r_head1),
        .o_state   (n_state),
        .o_res     (n_res)
    );

    // parser state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (rx_take) begin
                r_state <= n_state;
            end
            r_res_valid <= rx_take || (r_res_valid && !i_res_ready);
        end
    end

    // result payload and payload head
    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_frame_done     <= n_res.frame_done;
            r_error_code     <= n_res.err;
            r_motion_trigger <= n_res.trigger;
            if (n_res.wr_head0) begin
                r_head0 <= i_rx_byte;
            end
            if (n_res.wr_head1) begin
                r_head1 <= i_rx_byte;
            end
        end
    end

    // outputs
    assign o_res_valid      = r_res_valid;
    assign o_frame_done     = r_frame_done;
    assign o_error_code     = r_error_code;
    assign o_motion_active  = r_state.motion_state;
    assign o_motion_trigger = r_motion_trigger;
    assign o_error_count    = r_state.errors_seen;

    // checks
    `RFMP_CHECK_NEXT(a_err_clears, rx_take && (n_res.err != ERR_NONE), (r_state.hdr_matched == 3'd0) && (r_state.len_seen == 2'd0), "parser not cleared after error")
    `RFMP_CHECK(a_trig_frame, o_res_valid && o_motion_trigger, o_motion_active && o_frame_done, "trigger without completed active frame")
    `RFMP_CHECK(a_cnt_reported, $past(i_rst_n) && (r_state.errors_seen != $past(r_state.errors_seen)), o_res_valid && (r_error_code != ERR_NONE), "error count moved without error result")

endmodule
